### rtl/core/anat_pkg.sv
// shared constants for the amicable number test unit
package anat_pkg;

  // default widths of the number and of the reported sums
  localparam int NUM_BITS_DEF = 16;
  localparam int SUM_BITS_DEF = 20;

  // headroom bits: d(n) < 8n for every n below 2^24, d(d(n)) < 8 d(n) as well
  localparam int OP_EXTRA  = 3;
  localparam int ACC_EXTRA = 3;

endpackage

### rtl/core/anat_div.sv
// iterative restoring divider, one quotient bit per cycle
module anat_div #(
  parameter int OP_BITS = anat_pkg::NUM_BITS_DEF + anat_pkg::OP_EXTRA
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [OP_BITS-1:0] dividend,
  input  logic [OP_BITS-1:0] divisor,
  output logic               done,
  output logic [OP_BITS-1:0] quotient,
  output logic [OP_BITS-1:0] remainder
);

  localparam int CNT_BITS = $clog2(OP_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [OP_BITS-1:0]  den;
  logic [OP_BITS-1:0]  quo;
  logic [OP_BITS-1:0]  rem;
  logic [OP_BITS:0]    rem_sh;
  logic [OP_BITS:0]    trial;
  logic                fits;

  assign rem_sh = {rem, quo[OP_BITS-1]};
  assign trial  = rem_sh - {1'b0, den};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(OP_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= trial[OP_BITS-1:0];
        quo <= {quo[OP_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[OP_BITS-1:0];
        quo <= {quo[OP_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/core/anat_sum.sv
// proper divisor sum by trial division, sequencing the shared divider
module anat_sum #(
  parameter int OP_BITS  = anat_pkg::NUM_BITS_DEF + anat_pkg::OP_EXTRA,
  parameter int ACC_BITS = OP_BITS + anat_pkg::ACC_EXTRA
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OP_BITS-1:0]  operand,
  output logic                done,
  output logic [ACC_BITS-1:0] sum
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_ADD   = 2'd3;

  logic [1:0]          state;
  logic [OP_BITS-1:0]  m;
  logic [OP_BITS-1:0]  i;
  logic [OP_BITS:0]    sq;
  logic [ACC_BITS-1:0] total;
  logic [OP_BITS-1:0]  cof;
  logic                divisible;
  logic                div_start;
  logic                div_done;
  logic [OP_BITS-1:0]  quo;
  logic [OP_BITS-1:0]  rem;

  // keep trying while i*i <= m; sq tracks i*i incrementally
  assign div_start = (state == S_CHECK) && (sq <= {1'b0, m});

  anat_div #(
    .OP_BITS(OP_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (m),
    .divisor  (i),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (operand < OP_BITS'(2)) begin
              done <= 1'b1;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (div_start) begin
            state <= S_WAIT;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          state <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      m     <= operand;
      i     <= OP_BITS'(1);
      sq    <= (OP_BITS + 1)'(1);
      total <= '0;
    end else if (state == S_WAIT && div_done) begin
      cof       <= quo;
      divisible <= (rem == '0);
      if (rem == '0) begin
        total <= total + {{(ACC_BITS - OP_BITS){1'b0}}, i};
      end
    end else if (state == S_ADD) begin
      // cofactor counts unless it is the square root or n itself
      if (divisible && (cof != i) && (i != OP_BITS'(1))) begin
        total <= total + {{(ACC_BITS - OP_BITS){1'b0}}, cof};
      end
      i  <= i + OP_BITS'(1);
      sq <= sq + {i, 1'b1};
    end
  end

  assign sum = total;

endmodule

### rtl/core/amicable_number_test_unit.sv
// amicable number test: aliquot sums d(n), d(d(n)) and the amicable flags
//
// input channel: in_valid/in_ready with number; one transaction per number.
// output channel: out_valid/out_ready with divisor_sum, partner_divisor_sum,
// is_amicable and is_smaller; exactly one result transaction per input.
// each number runs two trial-division passes, d(n) then d(d(n)), on one
// shared restoring divider, one division per candidate; candidates
// run from 1 to floor(sqrt(m)), and 0 and 1 skip the trial division.
// in_ready is high only between numbers. sums above 2^SUM_BITS-1 are shown
// saturated, the flags use the exact sums. a finished result waits in the
// output register while out_ready is low and the next number is already
// accepted; its own result then holds until the register drains.
// reset is synchronous and leaves the block idle with no result pending.
module amicable_number_test_unit #(
  parameter int NUM_BITS = anat_pkg::NUM_BITS_DEF,
  parameter int SUM_BITS = anat_pkg::SUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NUM_BITS-1:0] number,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SUM_BITS-1:0] divisor_sum,
  output logic [SUM_BITS-1:0] partner_divisor_sum,
  output logic                is_amicable,
  output logic                is_smaller
);

  localparam int OP_BITS  = NUM_BITS + anat_pkg::OP_EXTRA;
  localparam int ACC_BITS = OP_BITS + anat_pkg::ACC_EXTRA;
  localparam int EXT_BITS = ACC_BITS + SUM_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN1 = 2'd1;
  localparam logic [1:0] S_RUN2 = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state;
  logic [NUM_BITS-1:0] n;
  logic [ACC_BITS-1:0] d1;
  logic [ACC_BITS-1:0] d2;
  logic [ACC_BITS-1:0] n_ext;
  logic                sum_start;
  logic [OP_BITS-1:0]  sum_operand;
  logic                sum_done;
  logic [ACC_BITS-1:0] sum_val;
  logic                amic;
  logic                smaller;
  logic                load;

  function automatic logic [SUM_BITS-1:0] saturate(input logic [ACC_BITS-1:0] v);
    logic [EXT_BITS-1:0] ext;
    ext = {{SUM_BITS{1'b0}}, v};
    if (ext[EXT_BITS-1:SUM_BITS] != '0) begin
      return '1;
    end
    return ext[SUM_BITS-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign sum_start = (state == S_IDLE && in_valid) || (state == S_RUN1 && sum_done);
  // d(n) always fits in OP_BITS, so the second pass takes it exactly
  assign sum_operand = (state == S_IDLE) ? {{(OP_BITS - NUM_BITS){1'b0}}, number}
                                         : sum_val[OP_BITS-1:0];

  anat_sum #(
    .OP_BITS (OP_BITS),
    .ACC_BITS(ACC_BITS)
  ) u_sum (
    .clk    (clk),
    .rst    (rst),
    .start  (sum_start),
    .operand(sum_operand),
    .done   (sum_done),
    .sum    (sum_val)
  );

  assign n_ext   = {{(ACC_BITS - NUM_BITS){1'b0}}, n};
  assign amic    = (d2 == n_ext) && (d1 != n_ext);
  assign smaller = amic && (n_ext < d1);
  assign load    = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN1;
          end
        end
        S_RUN1: begin
          if (sum_done) begin
            state <= S_RUN2;
          end
        end
        S_RUN2: begin
          if (sum_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      n <= number;
    end
    if (state == S_RUN1 && sum_done) begin
      d1 <= sum_val;
    end
    if (state == S_RUN2 && sum_done) begin
      d2 <= sum_val;
    end
    if (load) begin
      divisor_sum         <= saturate(d1);
      partner_divisor_sum <= saturate(d2);
      is_amicable         <= amic;
      is_smaller          <= smaller;
    end
  end

  // the smaller flag only ever accompanies an amicable result
  a_smaller_amicable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!is_smaller || is_amicable))
    else $error("is_smaller set without is_amicable");

  // no new number is taken right after one is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after an input transaction");

  // the sum unit finishes only while a pass is running
  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    sum_done |-> (state == S_RUN1 || state == S_RUN2))
    else $error("sum unit finished outside a pass");

endmodule
